>>> hdl/dual_wheel_low_speed_pi_top_assert.svh
// Assertion macros for the checker file of the dual-wheel PI loop.
`ifndef DUAL_WHEEL_LOW_SPEED_PI_TOP_ASSERT_SVH
`define DUAL_WHEEL_LOW_SPEED_PI_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DWLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DWLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/dwlp_pkg.sv
// Shared types and constants for the dual-wheel low-speed PI loop.
package dwlp_pkg;

  // Fixed field widths
  localparam int GOAL_W   = 16;
  localparam int MEAS_W   = 24;
  localparam int CMD_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int GAIN_FRAC = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Parameter defaults
  localparam int SENSOR_FRAC_BITS_DEF = 8;
  localparam int ACC_WIDTH_DEF        = 48;

  // Register reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd49152;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd2949;
  localparam logic [LIMIT_W-1:0] MIN_GOAL_RST   = 15'd2;
  localparam logic [LIMIT_W-1:0] MAX_GOAL_RST   = 15'd10;
  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST  = 15'd13;

  // Item kinds
  localparam logic KIND_GOAL   = 1'b0;
  localparam logic KIND_SENSOR = 1'b1;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_MIN_GOAL   = 3'd2,
    REG_MAX_GOAL   = 3'd3,
    REG_OUT_LIMIT  = 3'd4
  } cfg_reg_t;

  // Current register settings
  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [LIMIT_W-1:0] min_goal;
    logic [LIMIT_W-1:0] max_goal;
    logic [LIMIT_W-1:0] out_limit;
  } cfg_t;

endpackage

>>> hdl/dwlp_cfg_regs.sv
// Configuration register file for the dual-wheel PI loop.
module dwlp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dwlp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dwlp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dwlp_pkg::cfg_t                    cfg
);

  // Writes are always accepted
  assign cfg_ready = 1'b1;

  // Register write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain  <= dwlp_pkg::PROP_GAIN_RST;
      cfg.integ_gain <= dwlp_pkg::INTEG_GAIN_RST;
      cfg.min_goal   <= dwlp_pkg::MIN_GOAL_RST;
      cfg.max_goal   <= dwlp_pkg::MAX_GOAL_RST;
      cfg.out_limit  <= dwlp_pkg::OUT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dwlp_pkg::cfg_reg_t'(cfg_index))
        dwlp_pkg::REG_PROP_GAIN:  cfg.prop_gain  <= cfg_data;
        dwlp_pkg::REG_INTEG_GAIN: cfg.integ_gain <= cfg_data;
        dwlp_pkg::REG_MIN_GOAL:   cfg.min_goal   <= cfg_data[dwlp_pkg::LIMIT_W-1:0];
        dwlp_pkg::REG_MAX_GOAL:   cfg.max_goal   <= cfg_data[dwlp_pkg::LIMIT_W-1:0];
        dwlp_pkg::REG_OUT_LIMIT:  cfg.out_limit  <= cfg_data[dwlp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/dwlp_wheel.sv
// One wheel of the PI loop: state registers and the combinational update path.
module dwlp_wheel #(
  parameter int SENSOR_FRAC_BITS = dwlp_pkg::SENSOR_FRAC_BITS_DEF,
  parameter int ACC_WIDTH        = dwlp_pkg::ACC_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   update,
  input  logic                                   kind,
  input  logic signed [dwlp_pkg::GOAL_W-1:0]     goal_in,
  input  logic signed [dwlp_pkg::MEAS_W-1:0]     meas_in,
  input  dwlp_pkg::cfg_t                         cfg,
  output logic                                   enabled_next,
  output logic signed [dwlp_pkg::CMD_W-1:0]      command
);

  localparam int GOAL_W    = dwlp_pkg::GOAL_W;
  localparam int MEAS_W    = dwlp_pkg::MEAS_W;
  localparam int GAIN_W    = dwlp_pkg::GAIN_W;
  localparam int LIMIT_W   = dwlp_pkg::LIMIT_W;
  localparam int CMD_W     = dwlp_pkg::CMD_W;
  localparam int ACC_FRAC  = SENSOR_FRAC_BITS + dwlp_pkg::GAIN_FRAC;
  localparam int GOAL_SH_W = GOAL_W + SENSOR_FRAC_BITS;
  localparam int ERR_W     = ((GOAL_SH_W > MEAS_W) ? GOAL_SH_W : MEAS_W) + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int P1_W      = DIFF_W + GAIN_W + 1;
  localparam int P2_W      = ERR_W + GAIN_W + 1;
  localparam int DELTA_W   = P1_W + 1;
  localparam int PRE_W     = GOAL_W + ACC_FRAC;
  localparam int MAX_A     = (ACC_WIDTH > DELTA_W) ? ACC_WIDTH : DELTA_W;
  localparam int WIDE_W    = ((MAX_A > PRE_W) ? MAX_A : PRE_W) + 1;
  localparam int RND_W     = ACC_WIDTH + 1;
  localparam int Q_W       = RND_W - ACC_FRAC;
  localparam int CMP_W     = (Q_W > LIMIT_W) ? Q_W : LIMIT_W;
  localparam int MAG_W     = GOAL_W + 1;

  // Saturation bounds of the accumulator, held in the wide adder format
  localparam logic signed [WIDE_W-1:0] ACC_HI =
    {{(WIDE_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] ACC_LO = ~ACC_HI;
  localparam logic [RND_W-1:0] RND_HALF =
    {{(RND_W-ACC_FRAC){1'b0}}, 1'b1, {(ACC_FRAC-1){1'b0}}};

  // State
  logic signed [GOAL_W-1:0]    goal;
  logic signed [ACC_WIDTH-1:0] acc;
  logic signed [ERR_W-1:0]     prev_err;
  logic                        enabled;

  logic signed [ERR_W-1:0]     goal_ext;
  logic signed [ERR_W-1:0]     meas_ext;
  logic signed [ERR_W-1:0]     err;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [P1_W-1:0]      p1;
  logic signed [P2_W-1:0]      p2;
  logic signed [DELTA_W-1:0]   delta;
  logic signed [WIDE_W-1:0]    sum_wide;
  logic signed [WIDE_W-1:0]    pre_wide;
  logic signed [WIDE_W-1:0]    sel_wide;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic [MAG_W-1:0]            goal_mag;
  logic                        in_window;
  logic                        acc_neg;
  logic [ACC_WIDTH-1:0]        acc_mag;
  logic [RND_W-1:0]            rnd;
  logic [CMP_W-1:0]            q_ext;
  logic [LIMIT_W-1:0]          q_cl;
  logic signed [CMD_W-1:0]     loop_cmd;

  // Error in sensor fixed point and its change since the last sample
  always_comb begin
    goal_ext = ERR_W'(goal);
    meas_ext = ERR_W'(meas_in);
    err      = (goal_ext <<< SENSOR_FRAC_BITS) - meas_ext;
    diff     = DIFF_W'(err) - DIFF_W'(prev_err);
  end

  // Two gain products, exact
  always_comb begin
    p1    = diff * $signed({1'b0, cfg.prop_gain});
    p2    = err * $signed({1'b0, cfg.integ_gain});
    delta = DELTA_W'(p1) + DELTA_W'(p2);
  end

  // Accumulator: preset on a goal item, saturating add on a sensor item
  always_comb begin
    sum_wide = WIDE_W'(acc) + WIDE_W'(delta);
    pre_wide = WIDE_W'(goal_in) <<< ACC_FRAC;
    sel_wide = (kind == dwlp_pkg::KIND_SENSOR) ? sum_wide : pre_wide;
    if (sel_wide > ACC_HI) begin
      acc_sat = ACC_HI[ACC_WIDTH-1:0];
    end else if (sel_wide < ACC_LO) begin
      acc_sat = ACC_LO[ACC_WIDTH-1:0];
    end else begin
      acc_sat = sel_wide[ACC_WIDTH-1:0];
    end
  end

  // Enable window on the goal magnitude
  always_comb begin
    goal_mag  = goal_in[GOAL_W-1] ? (MAG_W'(0) - MAG_W'(goal_in)) : MAG_W'(goal_in);
    in_window = (goal_mag >= MAG_W'(cfg.min_goal)) && (goal_mag <= MAG_W'(cfg.max_goal));
    enabled_next = (kind == dwlp_pkg::KIND_SENSOR) ? enabled : in_window;
  end

  // Round half away from zero, then clamp to the output limit
  always_comb begin
    acc_neg  = acc_sat[ACC_WIDTH-1];
    acc_mag  = acc_neg ? (ACC_WIDTH'(0) - acc_sat) : acc_sat;
    rnd      = {1'b0, acc_mag} + RND_HALF;
    q_ext    = CMP_W'(rnd[RND_W-1:ACC_FRAC]);
    q_cl     = (q_ext > CMP_W'(cfg.out_limit)) ? cfg.out_limit : q_ext[LIMIT_W-1:0];
    loop_cmd = acc_neg ? -$signed({1'b0, q_cl}) : $signed({1'b0, q_cl});
  end

  // Command select: goal pass-through unless closed loop on a sample
  always_comb begin
    if (kind == dwlp_pkg::KIND_GOAL) begin
      command = goal_in;
    end else if (enabled) begin
      command = loop_cmd;
    end else begin
      command = goal;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      goal     <= '0;
      acc      <= '0;
      prev_err <= '0;
      enabled  <= 1'b0;
    end else if (update) begin
      enabled <= enabled_next;
      if (kind == dwlp_pkg::KIND_GOAL) begin
        goal     <= goal_in;
        acc      <= acc_sat;
        prev_err <= '0;
      end else begin
        prev_err <= err;
        if (enabled) begin
          acc <= acc_sat;
        end
      end
    end
  end

endmodule

>>> hdl/dual_wheel_low_speed_pi_top.sv
// Top level of the two-wheel incremental PI speed loop.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    kind, left/right_goal, left/right_measured
//  out      source     out_valid / out_ready  left/right_command, loop_active
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is registered on entry; its result moves to the output register once that
// register is free, and one item is taken every cycle unless the output stalls. The
// per-wheel multiply-add, saturating accumulate, rounding and clamp form the logic
// between the two registers. A sensor item while the loop is idle yields no result.
// Synchronous reset clears the flags and wheel state and loads the register defaults.
// in_ready drops only while an item waits in the input register behind a full output.
module dual_wheel_low_speed_pi_top #(
  parameter int SENSOR_FRAC_BITS = dwlp_pkg::SENSOR_FRAC_BITS_DEF,
  parameter int ACC_WIDTH        = dwlp_pkg::ACC_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic signed [dwlp_pkg::GOAL_W-1:0]    left_goal,
  input  logic signed [dwlp_pkg::GOAL_W-1:0]    right_goal,
  input  logic signed [dwlp_pkg::MEAS_W-1:0]    left_measured,
  input  logic signed [dwlp_pkg::MEAS_W-1:0]    right_measured,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dwlp_pkg::CMD_W-1:0]     left_command,
  output logic signed [dwlp_pkg::CMD_W-1:0]     right_command,
  output logic                                  loop_active,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dwlp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dwlp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  dwlp_pkg::cfg_t cfg;

  // Input stage
  logic                                s1_valid;
  logic                                s1_kind;
  logic signed [dwlp_pkg::GOAL_W-1:0]  s1_left_goal;
  logic signed [dwlp_pkg::GOAL_W-1:0]  s1_right_goal;
  logic signed [dwlp_pkg::MEAS_W-1:0]  s1_left_meas;
  logic signed [dwlp_pkg::MEAS_W-1:0]  s1_right_meas;

  logic                                active;
  logic                                out_free;
  logic                                s1_move;
  logic                                s1_emit;
  logic                                left_en_next;
  logic                                right_en_next;
  logic signed [dwlp_pkg::CMD_W-1:0]   left_cmd_next;
  logic signed [dwlp_pkg::CMD_W-1:0]   right_cmd_next;

  dwlp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake flow
  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign s1_emit  = s1_move && ((s1_kind == dwlp_pkg::KIND_GOAL) || active);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind       <= kind;
      s1_left_goal  <= left_goal;
      s1_right_goal <= right_goal;
      s1_left_meas  <= left_measured;
      s1_right_meas <= right_measured;
    end
  end

  dwlp_wheel #(
    .SENSOR_FRAC_BITS (SENSOR_FRAC_BITS),
    .ACC_WIDTH        (ACC_WIDTH)
  ) u_left (
    .clk          (clk),
    .rst          (rst),
    .update       (s1_emit),
    .kind         (s1_kind),
    .goal_in      (s1_left_goal),
    .meas_in      (s1_left_meas),
    .cfg          (cfg),
    .enabled_next (left_en_next),
    .command      (left_cmd_next)
  );

  dwlp_wheel #(
    .SENSOR_FRAC_BITS (SENSOR_FRAC_BITS),
    .ACC_WIDTH        (ACC_WIDTH)
  ) u_right (
    .clk          (clk),
    .rst          (rst),
    .update       (s1_emit),
    .kind         (s1_kind),
    .goal_in      (s1_right_goal),
    .meas_in      (s1_right_meas),
    .cfg          (cfg),
    .enabled_next (right_en_next),
    .command      (right_cmd_next)
  );

  // Loop active flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_emit) begin
        active <= left_en_next || right_en_next;
      end
      if (s1_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_emit) begin
      left_command  <= left_cmd_next;
      right_command <= right_cmd_next;
      loop_active   <= left_en_next || right_en_next;
    end
  end

endmodule

>>> hdl/dwlp_checker.sv
// Port-level checks for the dual-wheel PI loop, bound to the top level.
`include "dual_wheel_low_speed_pi_top_assert.svh"

module dwlp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [dwlp_pkg::CMD_W-1:0]  left_command,
  input logic signed [dwlp_pkg::CMD_W-1:0]  right_command,
  input logic                               loop_active,
  input logic                               cfg_ready
);

  // A stalled result keeps its fields
  `DWLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_command) && $stable(right_command) && $stable(loop_active), "stalled result changed")

  // Input backpressure only comes from a full, untaken output register
  `DWLP_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled while output free")

  // Nothing is shown right after reset
  `DWLP_ASSERT_NOW(a_rst_empty, $past(rst), !out_valid && in_ready, "pipeline not empty after reset")

  // Register writes never stall
  `DWLP_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config port stalled")

endmodule

bind dual_wheel_low_speed_pi_top dwlp_checker u_dwlp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .left_command  (left_command),
  .right_command (right_command),
  .loop_active   (loop_active),
  .cfg_ready     (cfg_ready)
);
